>>> rtl/nmp_pkg.sv
// Shared types and constants of the node message parser.
// No dependencies; compiled first.
`default_nettype none

package nmp_pkg;

  localparam int ID_W   = 48;
  localparam int SEQ_W  = 30;
  localparam int CHAR_W = 8;
  localparam int KIND_W = 2;

  localparam longint unsigned SEQ_HW_MAX = 64'h3FFF_FFFF;

  // Verdict codes
  localparam logic [KIND_W-1:0] KIND_INVALID   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACK_OWN   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ACK_OTHER = 2'd3;

  // Characters
  localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_QMARK  = 8'h3F;
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;

  localparam logic [CHAR_W-1:0] ACK_PREFIX [4] = '{8'h41, 8'h43, 8'h4B, 8'h2D};

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   node_id;
    logic [SEQ_W-1:0]  seq;
    logic              sat;
  } nmp_verdict_t;

  typedef struct packed {
    logic              step;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } nmp_step_t;

  // Largest sequence value: 10^digits - 1, clipped to the result width.
  function automatic logic [SEQ_W-1:0] seq_cap_f(input int digits);
    longint unsigned v;
    int i;
    v = 64'd1;
    for (i = 0; i < digits && i < 18; i++) begin
      v = v * 64'd10;
    end
    v = v - 64'd1;
    return (v > SEQ_HW_MAX) ? SEQ_HW_MAX[SEQ_W-1:0] : v[SEQ_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/nmp_in_if.sv
// Character input channel: valid/ready plus one message byte and its end marker.
// Depends on nmp_pkg.
`default_nettype none

interface nmp_in_if;
  import nmp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

>>> rtl/nmp_out_if.sv
// Verdict output channel: valid/ready plus the parsed message fields.
// Depends on nmp_pkg.
`default_nettype none

interface nmp_out_if;
  import nmp_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] message_kind;
  logic [ID_W-1:0]   node_id;
  logic [SEQ_W-1:0]  sequence_res;
  logic              sequence_saturated;

  modport source (output valid, output message_kind, output node_id,
                  output sequence_res, output sequence_saturated, input ready);
  modport sink   (input valid, input message_kind, input node_id,
                  input sequence_res, input sequence_saturated, output ready);
endinterface

`default_nettype wire

>>> rtl/nmp_parse_core.sv
// Parse state registers and per-character next-state logic of the node message parser.
// Depends on nmp_pkg.
`default_nettype none

module nmp_parse_core #(
  parameter int ID_HEX_DIGITS  = 12,
  parameter int SEQ_DIGITS_MAX = 9
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire nmp_pkg::nmp_step_t   step_in,
  input  wire logic [nmp_pkg::ID_W-1:0] own_id,
  output nmp_pkg::nmp_verdict_t     verdict
);
  import nmp_pkg::*;

  localparam int FP_RAW = $clog2(ID_HEX_DIGITS + 1);
  localparam int FP_W   = (FP_RAW < 2) ? 2 : FP_RAW;
  localparam int CNT_W  = $clog2(SEQ_DIGITS_MAX + 1);
  localparam int PUSH_W = SEQ_W + 4;
  localparam logic [SEQ_W-1:0] SEQ_CAP = seq_cap_f(SEQ_DIGITS_MAX);

  localparam logic [3:0] PH_HEAD  = 4'd0;
  localparam logic [3:0] PH_QID   = 4'd1;
  localparam logic [3:0] PH_QSEQ  = 4'd2;
  localparam logic [3:0] PH_QMARK = 4'd3;
  localparam logic [3:0] PH_QEND  = 4'd4;
  localparam logic [3:0] PH_APRE  = 4'd5;
  localparam logic [3:0] PH_AID   = 4'd6;
  localparam logic [3:0] PH_ASEQ  = 4'd7;
  localparam logic [3:0] PH_DEAD  = 4'd8;

  logic [3:0]       phase_r, phase_nxt;
  logic [FP_W-1:0]  fp_r, fp_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ended_r, ended_nxt;
  logic             sat_r, sat_nxt;
  logic             term_r, term_nxt;

  // {valid, value}
  function automatic logic [4:0] hex_decode(input logic [CHAR_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  logic [CHAR_W-1:0] c;
  logic [4:0]        hex;
  logic              is_digit;
  logic              is_hyphen;
  logic [ID_W-1:0]   id_shift;
  logic              fp_lt4;
  logic              fp_is3;
  logic              fp_lt_id;
  logic              fp_eq_id;
  logic              ack_ok;

  // Sequence digit push, evaluated from the current state
  logic [PUSH_W-1:0] push_v;
  logic [SEQ_W-1:0]  push_acc;
  logic [CNT_W-1:0]  push_cnt;
  logic              push_sat;

  always_comb begin
    c         = step_in.char_code;
    hex       = hex_decode(c);
    is_digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    is_hyphen = (c == CHAR_HYPHEN);
    id_shift  = {id_r[ID_W-5:0], hex[3:0]};
    fp_lt4    = ((fp_r >> 2) == '0);
    fp_is3    = (fp_r == FP_W'(3));
    fp_lt_id  = (fp_r < FP_W'(ID_HEX_DIGITS));
    fp_eq_id  = (fp_r == FP_W'(ID_HEX_DIGITS));
    ack_ok    = fp_lt4 && (c == ACK_PREFIX[fp_r[1:0]]);

    push_v = {4'd0, seq_r} * PUSH_W'(10) + PUSH_W'(c[3:0]);
    if (cnt_r >= CNT_W'(SEQ_DIGITS_MAX) || sat_r) begin
      push_acc = SEQ_CAP;
      push_sat = 1'b1;
      push_cnt = cnt_r;
    end else if (push_v > PUSH_W'(SEQ_CAP)) begin
      push_acc = SEQ_CAP;
      push_sat = 1'b1;
      push_cnt = cnt_r + CNT_W'(1);
    end else begin
      push_acc = push_v[SEQ_W-1:0];
      push_sat = sat_r;
      push_cnt = cnt_r + CNT_W'(1);
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    fp_nxt    = fp_r;
    id_nxt    = id_r;
    seq_nxt   = seq_r;
    cnt_nxt   = cnt_r;
    ended_nxt = ended_r;
    sat_nxt   = sat_r;
    term_nxt  = term_r;
    if (!term_r) begin
      if (c == CHAR_NUL) begin
        term_nxt = 1'b1;
      end else begin
        case (phase_r)
          PH_HEAD: begin
            // Query ID and "ACK-" prefix overlap on 'A' and 'C'
            if (hex[4] && fp_lt_id) begin
              id_nxt    = id_shift;
              fp_nxt    = fp_r + FP_W'(1);
              phase_nxt = ack_ok ? PH_HEAD : PH_QID;
            end else if (is_hyphen && fp_eq_id) begin
              fp_nxt    = '0;
              phase_nxt = PH_QSEQ;
            end else if (ack_ok) begin
              id_nxt    = '0;
              fp_nxt    = fp_is3 ? '0 : fp_r + FP_W'(1);
              phase_nxt = fp_is3 ? PH_AID : PH_APRE;
            end else begin
              phase_nxt = PH_DEAD;
            end
          end
          PH_QID: begin
            if (hex[4] && fp_lt_id) begin
              id_nxt = id_shift;
              fp_nxt = fp_r + FP_W'(1);
            end else if (is_hyphen && fp_eq_id) begin
              fp_nxt    = '0;
              phase_nxt = PH_QSEQ;
            end else begin
              phase_nxt = PH_DEAD;
            end
          end
          PH_QSEQ: begin
            if (is_digit && cnt_r < CNT_W'(SEQ_DIGITS_MAX)) begin
              seq_nxt = push_acc;
              cnt_nxt = push_cnt;
              sat_nxt = push_sat;
            end else if (is_hyphen && cnt_r != '0) begin
              phase_nxt = PH_QMARK;
            end else begin
              phase_nxt = PH_DEAD;
            end
          end
          PH_QMARK: begin
            phase_nxt = (c == CHAR_QMARK) ? PH_QEND : PH_DEAD;
          end
          PH_APRE: begin
            if (ack_ok) begin
              id_nxt    = '0;
              fp_nxt    = fp_is3 ? '0 : fp_r + FP_W'(1);
              phase_nxt = fp_is3 ? PH_AID : PH_APRE;
            end else begin
              phase_nxt = PH_DEAD;
            end
          end
          PH_AID: begin
            if (hex[4] && fp_lt_id) begin
              id_nxt = id_shift;
              fp_nxt = fp_r + FP_W'(1);
            end else if (is_hyphen && fp_eq_id) begin
              fp_nxt    = '0;
              phase_nxt = PH_ASEQ;
            end else begin
              phase_nxt = PH_DEAD;
            end
          end
          PH_ASEQ: begin
            if (is_hyphen) begin
              phase_nxt = PH_DEAD;
            end else begin
              fp_nxt = FP_W'(1);
              if (is_digit && !ended_r) begin
                seq_nxt = push_acc;
                cnt_nxt = push_cnt;
                sat_nxt = push_sat;
              end else begin
                ended_nxt = 1'b1;
              end
            end
          end
          default: begin
            phase_nxt = PH_DEAD;
          end
        endcase
      end
    end
  end

  // Verdict from the state after this character
  always_comb begin
    verdict.kind    = KIND_INVALID;
    verdict.node_id = '0;
    verdict.seq     = '0;
    verdict.sat     = 1'b0;
    if (phase_nxt == PH_QEND) begin
      verdict.kind = KIND_QUERY;
    end else if (phase_nxt == PH_ASEQ && fp_nxt != '0) begin
      verdict.kind = (id_nxt == own_id) ? KIND_ACK_OWN : KIND_ACK_OTHER;
    end
    if (verdict.kind != KIND_INVALID) begin
      verdict.node_id = id_nxt;
      verdict.seq     = seq_nxt;
      verdict.sat     = sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step_in.step && step_in.last_char)) begin
      phase_r <= PH_HEAD;
      fp_r    <= '0;
      id_r    <= '0;
      seq_r   <= '0;
      cnt_r   <= '0;
      ended_r <= 1'b0;
      sat_r   <= 1'b0;
      term_r  <= 1'b0;
    end else if (step_in.step) begin
      phase_r <= phase_nxt;
      fp_r    <= fp_nxt;
      id_r    <= id_nxt;
      seq_r   <= seq_nxt;
      cnt_r   <= cnt_nxt;
      ended_r <= ended_nxt;
      sat_r   <= sat_nxt;
      term_r  <= term_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/node_message_parser_top.sv
// Top level of the node message parser: config register, parse core, verdict register.
// Depends on nmp_pkg, nmp_in_if, nmp_out_if and nmp_parse_core.
`default_nettype none

// Streaming parser for received radio messages. Characters come in one per transfer on
// in_chan; the transfer that carries last_char yields exactly one verdict on out_chan
// in the next cycle, after which the parse state starts over. Verdicts: invalid, query
// "ID-SEQ-?", ack for this node or ack for another node ("ACK-ID-SEQ"); the ack's ID is
// compared with own_id_r; the user must write it through cfg_we/cfg_wdata while the
// block is idle, which the block does not enforce. A zero byte ends the message early;
// later bytes are ignored up to last_char. Rate: one character per cycle, sustained.
// All per-character work is a single pass through the parse core's next-state logic
// into its state registers; the verdict sits in a one-entry output register, and
// in_chan stalls only while a verdict is held there and out_chan is not ready.
module node_message_parser_top #(
  parameter int ID_HEX_DIGITS  = 12,
  parameter int SEQ_DIGITS_MAX = 9
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  nmp_in_if.sink                        in_chan,
  nmp_out_if.source                     out_chan,
  input  wire logic                     cfg_we,
  input  wire logic [nmp_pkg::ID_W-1:0] cfg_wdata
);
  import nmp_pkg::*;

  localparam logic [SEQ_W-1:0] SEQ_CAP = seq_cap_f(SEQ_DIGITS_MAX);

  logic [ID_W-1:0] own_id_r;
  logic            out_valid_r, out_valid_nxt;
  nmp_verdict_t    verdict;
  nmp_verdict_t    verdict_r;
  nmp_step_t       step;
  logic            in_xfer;

  // Room in the verdict register, or it drains this cycle
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  assign step.step      = in_xfer;
  assign step.char_code = in_chan.char_code;
  assign step.last_char = in_chan.last_char;

  nmp_parse_core #(
    .ID_HEX_DIGITS  (ID_HEX_DIGITS),
    .SEQ_DIGITS_MAX (SEQ_DIGITS_MAX)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_in (step),
    .own_id  (own_id_r),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r <= '0;
    end else if (cfg_we) begin
      own_id_r <= cfg_wdata;
    end
  end

  // Verdict register: loads on the final character, clears once transferred
  always_comb begin
    if (in_xfer && in_chan.last_char) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_chan.last_char) begin
      verdict_r <= verdict;
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.message_kind       = verdict_r.kind;
  assign out_chan.node_id            = verdict_r.node_id;
  assign out_chan.sequence_res       = verdict_r.seq;
  assign out_chan.sequence_saturated = verdict_r.sat;

`ifndef ASSERT_OFF
  // Final character always produces a verdict next cycle
  a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_chan.last_char) |=> out_valid_r)
    else $error("final character transfer did not load a verdict");

  // Invalid verdicts carry all-zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && verdict_r.kind == KIND_INVALID) |->
      (verdict_r.node_id == '0 && verdict_r.seq == '0 && !verdict_r.sat))
    else $error("invalid verdict with nonzero fields");

  // Sequence value never exceeds its saturation cap
  a_seq_capped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (verdict_r.seq <= SEQ_CAP))
    else $error("sequence value above cap");
`endif

endmodule

`default_nettype wire

>>> sim/nmp_checker.sv
`timescale 1ns / 100ps
// Verdict checker for the node message parser: watches both channels and the id port,
// predicts one verdict per message and compares each one that comes out.
// Depends on nmp_pkg, nmp_in_if and nmp_out_if.

module nmp_checker #(
  parameter int ID_DIGITS  = 12,
  parameter int SEQ_DIGITS = 9
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  nmp_in_if                             in_chan,
  nmp_out_if                            out_chan,
  input  wire logic                     cfg_we,
  input  wire logic [nmp_pkg::ID_W-1:0] cfg_wdata,
  output int                            mismatch_count,
  output int                            verdicts_pending
);
  import nmp_pkg::*;

  localparam int REPORT_LINES = 40;

  typedef enum logic [3:0] {
    ST_START, ST_Q_ID, ST_Q_SEQ, ST_Q_MARK, ST_Q_DONE,
    ST_A_PREFIX, ST_A_ID, ST_A_SEQ, ST_REJECT
  } parse_phase_e;

  parse_phase_e      phase;
  int                pos;
  logic [ID_W-1:0]   id_acc;
  longint unsigned   seq_acc;
  int                seq_digits;
  bit                seq_ended;
  bit                seq_sat;
  bit                msg_ended;
  logic [ID_W-1:0]   own_id;
  nmp_verdict_t      verdicts_due [$];

  function automatic int nibble_of(logic [CHAR_W-1:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // 10^SEQ_DIGITS - 1, clipped to what the result field holds
  function automatic longint unsigned seq_ceiling();
    longint unsigned v;
    v = 1;
    for (int i = 0; i < SEQ_DIGITS && i < 18; i++) v = v * 64'd10;
    v = v - 64'd1;
    return (v > SEQ_HW_MAX) ? SEQ_HW_MAX : v;
  endfunction

  function automatic void clear_parse();
    phase      = ST_START;
    pos        = 0;
    id_acc     = '0;
    seq_acc    = 0;
    seq_digits = 0;
    seq_ended  = 1'b0;
    seq_sat    = 1'b0;
    msg_ended  = 1'b0;
  endfunction

  function automatic void push_seq_digit(int d);
    longint unsigned ceiling;
    longint unsigned v;
    ceiling = seq_ceiling();
    if (seq_digits >= SEQ_DIGITS || seq_sat) begin
      seq_acc = ceiling;
      seq_sat = 1'b1;
      return;
    end
    v = seq_acc * 64'd10 + 64'(d);
    if (v > ceiling) begin
      v = ceiling;
      seq_sat = 1'b1;
    end
    seq_acc = v;
    seq_digits++;
  endfunction

  function automatic bit take_query_id(logic [CHAR_W-1:0] c);
    int h;
    h = nibble_of(c);
    if (h >= 0 && pos < ID_DIGITS) begin
      id_acc = {id_acc[ID_W-5:0], h[3:0]};
      pos++;
      phase = ST_Q_ID;
      return 1'b1;
    end
    if (c == CHAR_HYPHEN && pos == ID_DIGITS) begin
      pos = 0;
      phase = ST_Q_SEQ;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void step_ack_prefix(int next_pos);
    id_acc = '0;
    if (next_pos >= 4) begin
      pos = 0;
      phase = ST_A_ID;
    end else begin
      pos = next_pos;
      phase = ST_A_PREFIX;
    end
  endfunction

  function automatic void consume_char(logic [CHAR_W-1:0] c);
    bit is_digit;
    bit prefix_hit;
    int h;
    int p;
    is_digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
    h = nibble_of(c);
    case (phase)
      ST_START: begin
        // "AC" is also hex, so the start state keeps both readings open
        p = pos;
        prefix_hit = (p < 4) && (c == ACK_PREFIX[p & 3]);
        if (take_query_id(c)) begin
          if (prefix_hit && phase == ST_Q_ID) phase = ST_START;
        end else if (prefix_hit) begin
          step_ack_prefix(p + 1);
        end else begin
          phase = ST_REJECT;
        end
      end
      ST_Q_ID: begin
        if (!take_query_id(c)) phase = ST_REJECT;
      end
      ST_Q_SEQ: begin
        if (is_digit && seq_digits < SEQ_DIGITS) push_seq_digit(int'(c - CHAR_ZERO));
        else if (c == CHAR_HYPHEN && seq_digits >= 1) phase = ST_Q_MARK;
        else phase = ST_REJECT;
      end
      ST_Q_MARK: begin
        phase = (c == CHAR_QMARK) ? ST_Q_DONE : ST_REJECT;
      end
      ST_A_PREFIX: begin
        if (pos < 4 && c == ACK_PREFIX[pos & 3]) step_ack_prefix(pos + 1);
        else phase = ST_REJECT;
      end
      ST_A_ID: begin
        if (h >= 0 && pos < ID_DIGITS) begin
          id_acc = {id_acc[ID_W-5:0], h[3:0]};
          pos++;
        end else if (c == CHAR_HYPHEN && pos == ID_DIGITS) begin
          pos = 0;
          phase = ST_A_SEQ;
        end else begin
          phase = ST_REJECT;
        end
      end
      ST_A_SEQ: begin
        if (c == CHAR_HYPHEN) begin
          phase = ST_REJECT;
        end else begin
          pos = 1;
          if (is_digit && !seq_ended) push_seq_digit(int'(c - CHAR_ZERO));
          else seq_ended = 1'b1;
        end
      end
      default: phase = ST_REJECT;
    endcase
  endfunction

  function automatic void take_char(logic [CHAR_W-1:0] c, logic last);
    nmp_verdict_t v;
    if (!msg_ended) begin
      if (c == CHAR_NUL) msg_ended = 1'b1;
      else consume_char(c);
    end
    if (last) begin
      v = '0;
      if (phase == ST_Q_DONE) v.kind = KIND_QUERY;
      else if (phase == ST_A_SEQ && pos >= 1)
        v.kind = (id_acc == own_id) ? KIND_ACK_OWN : KIND_ACK_OTHER;
      if (v.kind != KIND_INVALID) begin
        v.node_id = id_acc;
        v.seq     = seq_acc[SEQ_W-1:0];
        v.sat     = seq_sat;
      end
      verdicts_due.push_back(v);
      clear_parse();
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_count < REPORT_LINES)
      $display("%0t: %0s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch
    nmp_verdict_t got;
    nmp_verdict_t want;
    if (!rst_n) begin
      own_id = '0;
      clear_parse();
      verdicts_due.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) own_id = cfg_wdata;
      // older verdict leaves before a new one is queued on the same edge
      if (out_chan.valid && out_chan.ready) begin
        got.kind    = out_chan.message_kind;
        got.node_id = out_chan.node_id;
        got.seq     = out_chan.sequence_res;
        got.sat     = out_chan.sequence_saturated;
        if (verdicts_due.size() == 0) begin
          report_mismatch("unexpected verdict, message_kind", 64'(got.kind), 64'd0);
        end else begin
          want = verdicts_due.pop_front();
          if (got.kind !== want.kind)
            report_mismatch("message_kind", 64'(got.kind), 64'(want.kind));
          if (got.node_id !== want.node_id)
            report_mismatch("node_id", 64'(got.node_id), 64'(want.node_id));
          if (got.seq !== want.seq)
            report_mismatch("sequence_res", 64'(got.seq), 64'(want.seq));
          if (got.sat !== want.sat)
            report_mismatch("sequence_saturated", 64'(got.sat), 64'(want.sat));
        end
      end
      if (in_chan.valid && in_chan.ready) take_char(in_chan.char_code, in_chan.last_char);
    end
    verdicts_pending <= verdicts_due.size();
  end

endmodule

>>> sim/tb_node_message_parser_top.sv
`timescale 1ns / 100ps
// Testbench top for node_message_parser_top: clock, reset, message stimulus, receiver
// stalls, watchdog and the final verdict. Depends on nmp_pkg, the channel interfaces,
// the parser RTL and nmp_checker.

module tb_node_message_parser_top;
  import nmp_pkg::*;

  localparam int ID_DIGITS      = 12;
  localparam int SEQ_DIGITS     = 9;
  localparam int PHASES         = 8;
  localparam int RANDOM_CHARS   = 150;   // per phase, bytes the parser acts on
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
  localparam int SETTLE_CYCLES  = 4;     // settling margin after the verdict register

  localparam logic [CHAR_W-1:0] CH_UPPER_A = "A";
  localparam logic [CHAR_W-1:0] CH_LOWER_A = "a";
  localparam string NOISE_CHARS = "ACK-0123456789abcdefABCDEF?xZ ";

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [ID_W-1:0] cfg_wdata;

  nmp_in_if  in_chan ();
  nmp_out_if out_chan ();

  int                mismatch_count;
  int                verdicts_pending;
  int                send_idle_pct;
  int                recv_stall_pct;
  int                chars_sent;
  bit                hold_req;
  logic [ID_W-1:0]   own_id;
  logic [CHAR_W-1:0] msg_bytes [$];

  node_message_parser_top #(
    .ID_HEX_DIGITS (ID_DIGITS),
    .SEQ_DIGITS_MAX(SEQ_DIGITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  nmp_checker #(
    .ID_DIGITS (ID_DIGITS),
    .SEQ_DIGITS(SEQ_DIGITS)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_chan         (in_chan),
    .out_chan        (out_chan),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .verdicts_pending(verdicts_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Message building. Everything lands in msg_bytes; send_message drives it out.
  // ---------------------------------------------------------------------------

  // One hex digit, letters in a random case
  function automatic logic [CHAR_W-1:0] hex_char(logic [3:0] nib);
    logic [CHAR_W-1:0] letter_base;
    letter_base = $urandom_range(1) ? CH_UPPER_A : CH_LOWER_A;
    return (nib < 10) ? CHAR_ZERO + CHAR_W'(nib) : letter_base + CHAR_W'(nib) - 8'd10;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
  endfunction

  function automatic void push_id(logic [ID_W-1:0] id);
    for (int i = ID_DIGITS - 1; i >= 0; i--) msg_bytes.push_back(hex_char(id[4*i +: 4]));
  endfunction

  function automatic void push_digits(int n);
    repeat (n) msg_bytes.push_back(CHAR_ZERO + CHAR_W'($urandom_range(9)));
  endfunction

  // Some ids open with "AC" so the start state has to sort query from ack late
  function automatic logic [ID_W-1:0] random_id();
    logic [ID_W-1:0] id;
    id = {16'($urandom), $urandom};
    if ($urandom_range(9) == 0) id[ID_W-1 -: 8] = 8'hAC;
    return id;
  endfunction

  function automatic void build_query(int n_digits);
    push_id(random_id());
    msg_bytes.push_back(CHAR_HYPHEN);
    push_digits(n_digits);
    push_text("-?");
  endfunction

  function automatic void build_ack();
    int sel;
    logic [CHAR_W-1:0] b;
    push_text("ACK-");
    push_id(($urandom_range(99) < 40) ? own_id : random_id());
    msg_bytes.push_back(CHAR_HYPHEN);
    sel = $urandom_range(99);
    if (sel < 80) push_digits($urandom_range(1, SEQ_DIGITS));
    else if (sel < 92) push_digits($urandom_range(SEQ_DIGITS + 1, SEQ_DIGITS + 5));
    // no digits at all: value stays zero unless the tail holds digits; the ack still counts if a tail follows
    if (sel >= 92 || $urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        b = CHAR_W'($urandom_range(255));
        if (b == CHAR_HYPHEN) b = "x";
        msg_bytes.push_back(b);
      end
    end
  endfunction

  // Mostly well-formed messages with random content; the rest broken or noise.
  function automatic void build_random_message();
    int sel;
    int n;
    sel = $urandom_range(99);
    msg_bytes.delete();
    if (sel < 35) begin
      build_query($urandom_range(1, SEQ_DIGITS));
    end else if (sel < 70) begin
      build_ack();
    end else begin
      if ($urandom_range(1)) build_query($urandom_range(0, SEQ_DIGITS + 2));
      else build_ack();
      if (sel < 80) begin
        msg_bytes[$urandom_range(msg_bytes.size() - 1)] = CHAR_W'($urandom_range(255));
      end else if (sel < 86) begin
        n = $urandom_range(1, msg_bytes.size() - 1);
        while (msg_bytes.size() > n) void'(msg_bytes.pop_back());
      end else if (sel < 92) begin
        // early end, with bytes behind it that must be ignored
        msg_bytes.insert($urandom_range(msg_bytes.size() - 1), CHAR_NUL);
        repeat ($urandom_range(0, 3)) msg_bytes.push_back(CHAR_W'($urandom_range(255)));
      end else if (sel < 96) begin
        msg_bytes.push_back(CHAR_W'($urandom_range(255)));
      end else begin
        msg_bytes.delete();
        repeat ($urandom_range(1, 24)) begin
          if ($urandom_range(1))
            msg_bytes.push_back(NOISE_CHARS[$urandom_range(NOISE_CHARS.len() - 1)]);
          else
            msg_bytes.push_back(CHAR_W'($urandom_range(255)));
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Channel driving
  // ---------------------------------------------------------------------------

  // Drives msg_bytes, one byte per transfer, last_char on the final byte. valid is
  // left high after the last transfer; the next message or drain_verdicts takes over.
  task automatic send_message();
    bit ignoring;
    ignoring = 1'b0;
    foreach (msg_bytes[i]) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_chan.valid <= 1'b0;
        @(posedge clk);
      end
      in_chan.valid     <= 1'b1;
      in_chan.char_code <= msg_bytes[i];
      in_chan.last_char <= (i == msg_bytes.size() - 1);
      @(posedge clk);
      while (!in_chan.ready) @(posedge clk);
      // bytes after a zero byte are dropped by the parser; not counted
      if (!ignoring) chars_sent++;
      if (msg_bytes[i] == CHAR_NUL) ignoring = 1'b1;
    end
    msg_bytes.delete();
  endtask

  task automatic send_text(string s);
    push_text(s);
    send_message();
  endtask

  // Sender goes quiet until every verdict is back, then lets the pipe settle.
  // The first edge lets the checker count a verdict queued on the last transfer.
  task automatic drain_verdicts();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_own_id(logic [ID_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    own_id = v;
  endtask

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 75; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 75; end
      default:       begin send_idle_pct = 37; recv_stall_pct = 37; end
    endcase
  endtask

  // Register holds 0 here, so the all-zero id acks are for this node.
  task automatic directed_messages();
    msg_bytes.push_back(CHAR_NUL);            // empty message
    send_message();
    send_text("FFFFFFFFFFFF-999999999-?");    // largest id and sequence
    send_text("000000000000-0-?");
    send_text("abcdefABCDEF-12-?");           // mixed case id
    send_text("ACabcd012345-7-?");            // query id that starts like the prefix
    send_text("0123456789ab-1234567890-?");   // one query digit too many
    send_text("0123456789ab-42-?Z");          // byte after a complete query
    send_text("0123456789ab-12-");            // question mark missing
    send_text("0123456789a-1-?");             // short id
    send_text("ACK-000000000000-5");          // ack for this node
    send_text("ACK-FFFFFFFFFFFF-0");          // ack for another node
    send_text("ACK-123456789abc-123456789012"); // saturating sequence
    send_text("ACK-123456789abc-77xy");       // digits then other bytes
    send_text("ACK-123456789abc-q");          // no leading digits
    send_text("ACK-123456789abc-");           // empty sequence
    send_text("ACK-123456789abc-1-2");        // hyphen inside the sequence
    send_text("ack-123456789abc-1");          // prefix is case sensitive
    // zero byte in the middle: the rest is ignored up to last_char
    push_text("0123456789ab-5");
    msg_bytes.push_back(CHAR_NUL);
    push_text("-?");
    send_message();
    // zero byte as the last byte after a complete query
    push_text("0123456789ab-5-?");
    msg_bytes.push_back(CHAR_NUL);
    send_message();
    msg_bytes.push_back(8'hFF);               // high byte alone
    send_message();
    push_text("AC-");
    msg_bytes.push_back(8'h80);
    send_message();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, then phases with their own id and idling pattern
  // ---------------------------------------------------------------------------
  initial begin
    logic [ID_W-1:0] next_id;
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.char_code <= '0;
    in_chan.last_char <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    hold_req       = 1'b0;
    own_id         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    chars_sent     = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase_no = 0; phase_no < PHASES; phase_no++) begin
      set_idling(idle_mode_e'(phase_no % 4));
      // extremes first, then random ids; the block is idle at every write
      case (phase_no)
        0:       next_id = '0;
        1:       next_id = '1;
        2:       next_id = 48'h8000_0000_0001;
        default: next_id = random_id();
      endcase
      write_own_id(next_id);
      if (phase_no == 0) directed_messages();
      // long receiver hold-off while the sender keeps offering: input must back up
      if (phase_no % 4 == 0) hold_req = 1'b1;
      chars_sent = 0;
      while (chars_sent < RANDOM_CHARS) begin
        build_random_message();
        send_message();
        if ($urandom_range(19) == 0) drain_verdicts();
      end
      drain_verdicts();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/nmp_pkg.sv
rtl/nmp_in_if.sv
rtl/nmp_out_if.sv
rtl/nmp_parse_core.sv
rtl/node_message_parser_top.sv
sim/nmp_checker.sv
sim/tb_node_message_parser_top.sv
